// File: hdl/pid_ema_derivative_controller_top_assert.svh
// assertion macros shared by the controller files
// PEDC_ASSERT is quiet while aresetn is low, PEDC_ASSERT_RST also checks in reset
`ifndef PID_EMA_DERIVATIVE_CONTROLLER_TOP_ASSERT_SVH
`define PID_EMA_DERIVATIVE_CONTROLLER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define PEDC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`define PEDC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define PEDC_ASSERT(label, prop, msg)

`define PEDC_ASSERT_RST(label, prop, msg)

`endif

`endif

// File: hdl/pedc_pkg.sv
package pedc_pkg;

    // defaults for the top level parameters
    localparam int GAIN_FRAC_BITS_DEF = 12;
    localparam int OUT_LIMIT_DEF      = 127;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // field and state widths
    localparam int SAMPLE_W   = 16;
    localparam int ERR_W      = 17;
    localparam int DERR_W     = 18;
    localparam int INTEG_W    = 25;
    localparam int ISUM_W     = 35;
    localparam int FILT_W     = 36;
    localparam int DIFF_W     = 37;
    localparam int GAIN_W     = 24;
    localparam int CAP_W      = 24;
    localparam int WIN_W      = 17;
    localparam int ALPHA_W    = 17;
    localparam int SPLIT_W    = 18;
    localparam int DERIV_FRAC = 16;

    // shared multiplier and accumulator
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 64;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

    // non-derivative part beyond this saturates outright
    localparam logic signed [ACC_W-1:0] HUGE_POS = 64'sh0000_4000_0000_0000;
    localparam logic signed [ACC_W-1:0] HUGE_NEG = -64'sh0000_4000_0000_0000;

    // reset values of the registers
    localparam logic [CAP_W-1:0]   CAP_RESET       = 24'd100000;
    localparam logic [WIN_W-1:0]   WIN_INNER_RESET = 17'd0;
    localparam logic [WIN_W-1:0]   WIN_OUTER_RESET = 17'h1FFFF;
    localparam logic [GAIN_W-1:0]  GAIN_RESET      = 24'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P       = 3'd0,
        REG_GAIN_I       = 3'd1,
        REG_GAIN_D       = 3'd2,
        REG_GAIN_FF      = 3'd3,
        REG_INTEGRAL_CAP = 3'd4,
        REG_WINDOW_INNER = 3'd5,
        REG_WINDOW_OUTER = 3'd6,
        REG_EMA_ALPHA    = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [GAIN_W-1:0]  gain_ff;
        logic [CAP_W-1:0]   integral_cap;
        logic [WIN_W-1:0]   window_inner;
        logic [WIN_W-1:0]   window_outer;
        logic [ALPHA_W-1:0] ema_alpha;
    } pedc_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDT,
        ST_XH,
        ST_XL,
        ST_GP,
        ST_GI,
        ST_GFF,
        ST_DL,
        ST_DH,
        ST_DHACC,
        ST_QUOT,
        ST_DONE
    } ctrl_state_t;

    // multiplier operand pairs
    typedef enum logic [2:0] {
        MUL_E_DT,
        MUL_XH_ALPHA,
        MUL_XL_ALPHA,
        MUL_E_GP,
        MUL_I_GI,
        MUL_T_GFF,
        MUL_FL_GD,
        MUL_FH_GD
    } mul_sel_t;

    // what happens to the product registered in the previous cycle
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_ISUM,
        ACC_LOAD_HI,
        ACC_ADD,
        ACC_FILT_LOAD,
        ACC_SHIFT_ADD,
        ACC_ADD_HI,
        ACC_QUOT
    } acc_op_t;

    typedef struct packed {
        logic     capture;
        logic     diff_load;
        logic     clamp_load;
        logic     out_load;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
    } pedc_cmd_t;

    typedef struct packed {
        logic out_free;
    } pedc_status_t;

endpackage

// File: hdl/pedc_cfg_regs.sv
module pedc_cfg_regs
    import pedc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output pedc_cfg_t             cfg
);

    pedc_cfg_t cfg_reg;

    // register file, one write per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p       <= GAIN_RESET;
            cfg_reg.gain_i       <= GAIN_RESET;
            cfg_reg.gain_d       <= GAIN_RESET;
            cfg_reg.gain_ff      <= GAIN_RESET;
            cfg_reg.integral_cap <= CAP_RESET;
            cfg_reg.window_inner <= WIN_INNER_RESET;
            cfg_reg.window_outer <= WIN_OUTER_RESET;
            cfg_reg.ema_alpha    <= ALPHA_ONE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                REG_GAIN_P:       cfg_reg.gain_p       <= cfg_wr_data[GAIN_W-1:0];
                REG_GAIN_I:       cfg_reg.gain_i       <= cfg_wr_data[GAIN_W-1:0];
                REG_GAIN_D:       cfg_reg.gain_d       <= cfg_wr_data[GAIN_W-1:0];
                REG_GAIN_FF:      cfg_reg.gain_ff      <= cfg_wr_data[GAIN_W-1:0];
                REG_INTEGRAL_CAP: cfg_reg.integral_cap <= cfg_wr_data[CAP_W-1:0];
                REG_WINDOW_INNER: cfg_reg.window_inner <= cfg_wr_data[WIN_W-1:0];
                REG_WINDOW_OUTER: cfg_reg.window_outer <= cfg_wr_data[WIN_W-1:0];
                REG_EMA_ALPHA:    cfg_reg.ema_alpha    <= cfg_wr_data[ALPHA_W-1:0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/pedc_ctrl.sv
`include "pid_ema_derivative_controller_top_assert.svh"

module pedc_ctrl
    import pedc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  pedc_status_t status,
    output pedc_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EDT;
                end
            end
            ST_EDT:   state_next = ST_XH;
            ST_XH:    state_next = ST_XL;
            ST_XL:    state_next = ST_GP;
            ST_GP:    state_next = ST_GI;
            ST_GI:    state_next = ST_GFF;
            ST_GFF:   state_next = ST_DL;
            ST_DL:    state_next = ST_DH;
            ST_DH:    state_next = ST_DHACC;
            ST_DHACC: state_next = ST_QUOT;
            ST_QUOT:  state_next = ST_DONE;
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        s_ready        = 1'b0;
        cmd.capture    = 1'b0;
        cmd.diff_load  = 1'b0;
        cmd.clamp_load = 1'b0;
        cmd.out_load   = 1'b0;
        cmd.mul_sel    = MUL_E_DT;
        cmd.acc_op     = ACC_HOLD;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_EDT: begin
                cmd.mul_sel   = MUL_E_DT;
                cmd.diff_load = 1'b1;
            end
            ST_XH: begin
                cmd.mul_sel = MUL_XH_ALPHA;
                cmd.acc_op  = ACC_ISUM;
            end
            ST_XL: begin
                cmd.mul_sel    = MUL_XL_ALPHA;
                cmd.acc_op     = ACC_LOAD_HI;
                cmd.clamp_load = 1'b1;
            end
            ST_GP: begin
                cmd.mul_sel = MUL_E_GP;
                cmd.acc_op  = ACC_ADD;
            end
            ST_GI: begin
                cmd.mul_sel = MUL_I_GI;
                cmd.acc_op  = ACC_FILT_LOAD;
            end
            ST_GFF: begin
                cmd.mul_sel = MUL_T_GFF;
                cmd.acc_op  = ACC_ADD;
            end
            ST_DL: begin
                cmd.mul_sel = MUL_FL_GD;
                cmd.acc_op  = ACC_ADD;
            end
            ST_DH: begin
                cmd.mul_sel = MUL_FH_GD;
                cmd.acc_op  = ACC_SHIFT_ADD;
            end
            ST_DHACC: begin
                cmd.acc_op = ACC_ADD_HI;
            end
            ST_QUOT: begin
                cmd.acc_op = ACC_QUOT;
            end
            ST_DONE: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                cmd.acc_op = ACC_HOLD;
            end
        endcase
    end

    `PEDC_ASSERT(a_accept_starts_step, (s_valid && s_ready) |=> (state_reg == ST_EDT), "accepted word did not start the sequence")
    `PEDC_ASSERT(a_done_waits, (state_reg == ST_DONE && !status.out_free) |=> (state_reg == ST_DONE), "result left while output register was full")
    `PEDC_ASSERT(a_ready_after_done, (state_reg == ST_DONE && status.out_free) |=> s_ready, "input not reopened after result load")

endmodule

// File: hdl/pedc_datapath.sv
`include "pid_ema_derivative_controller_top_assert.svh"

module pedc_datapath
    import pedc_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    parameter int OUT_LIMIT      = OUT_LIMIT_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  pedc_cfg_t                          cfg,
    input  logic signed [SAMPLE_W-1:0]         s_target,
    input  logic signed [SAMPLE_W-1:0]         s_measured,
    input  logic        [SAMPLE_W-1:0]         s_elapsed_ticks,
    input  pedc_cmd_t                          cmd,
    output pedc_status_t                       status,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [$clog2(OUT_LIMIT+1):0] m_drive,
    output logic                               m_saturated
);

    localparam int DRIVE_W = $clog2(OUT_LIMIT + 1) + 1;
    localparam int SHIFT   = GAIN_FRAC_BITS + DERIV_FRAC;
    localparam int QW      = ACC_W - SHIFT;
    localparam logic signed [QW-1:0]      Q_LIM = QW'(OUT_LIMIT);
    localparam logic signed [DRIVE_W-1:0] D_LIM = DRIVE_W'(OUT_LIMIT);

    // sample registers
    logic signed [SAMPLE_W-1:0] tgt_reg;
    logic signed [ERR_W-1:0]    e_reg;
    logic        [SAMPLE_W-1:0] dt_reg;

    // controller state carried between samples
    logic signed [ERR_W-1:0]    prev_reg;
    logic signed [INTEG_W-1:0]  integ_reg;
    logic signed [FILT_W-1:0]   f_reg;

    // working registers
    logic signed [DIFF_W-1:0]   diff_reg;
    logic signed [DIFF_W-1:0]   diff_next;
    logic signed [ISUM_W-1:0]   isum_reg;
    logic signed [ISUM_W-1:0]   isum_next;
    logic signed [INTEG_W-1:0]  integ_new_reg;
    logic signed [INTEG_W-1:0]  integ_new_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [FILT_W-1:0]   f_next;
    logic signed [QW-1:0]       q_reg;
    logic signed [QW-1:0]       q_next;
    logic                       huge_reg;
    logic                       huge_next;
    logic                       huge_neg_reg;

    // output register
    logic                       m_valid_reg;
    logic signed [DRIVE_W-1:0]  m_drive_reg;
    logic                       m_saturated_reg;
    logic signed [DRIVE_W-1:0]  drive_next;
    logic                       sat_next;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic        [ALPHA_W-1:0]  alpha_eff;
    logic signed [DERR_W-1:0]   derr;
    logic signed [DIFF_W-1:0]   d_scaled;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [ISUM_W-1:0]   cap_pos;
    logic signed [ISUM_W-1:0]   cap_neg;
    logic signed [ISUM_W-1:0]   clamped;
    logic        [ERR_W-1:0]    e_mag;
    logic                       frozen;
    logic signed [DIFF_W-1:0]   f_sum;
    logic                       f_round;
    logic                       q_round;

    // alpha above one acts as one
    assign alpha_eff = (cfg.ema_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.ema_alpha;

    // derivative with 16 fraction bits, quartered when negative, minus filter state
    always_comb begin
        derr = {e_reg[ERR_W-1], e_reg} - {prev_reg[ERR_W-1], prev_reg};
        if (derr[DERR_W-1]) begin
            d_scaled = {{5{derr[DERR_W-1]}}, derr, 14'b0};
        end else begin
            d_scaled = {{3{derr[DERR_W-1]}}, derr, 16'b0};
        end
        diff_next = d_scaled - {f_reg[FILT_W-1], f_reg};
    end

    // shared multiplier operand select
    always_comb begin
        unique case (cmd.mul_sel)
            MUL_E_DT: begin
                mul_a = {{(MUL_A_W-ERR_W){e_reg[ERR_W-1]}}, e_reg};
                mul_b = {{(MUL_B_W-SAMPLE_W){1'b0}}, dt_reg};
            end
            MUL_XH_ALPHA: begin
                mul_a = {{(MUL_A_W-DIFF_W+SPLIT_W){diff_reg[DIFF_W-1]}},
                         diff_reg[DIFF_W-1:SPLIT_W]};
                mul_b = {{(MUL_B_W-ALPHA_W){1'b0}}, alpha_eff};
            end
            MUL_XL_ALPHA: begin
                mul_a = {{(MUL_A_W-SPLIT_W){1'b0}}, diff_reg[SPLIT_W-1:0]};
                mul_b = {{(MUL_B_W-ALPHA_W){1'b0}}, alpha_eff};
            end
            MUL_E_GP: begin
                mul_a = {{(MUL_A_W-ERR_W){e_reg[ERR_W-1]}}, e_reg};
                mul_b = {cfg.gain_p[GAIN_W-1], cfg.gain_p};
            end
            MUL_I_GI: begin
                mul_a = {integ_new_reg[INTEG_W-1], integ_new_reg};
                mul_b = {cfg.gain_i[GAIN_W-1], cfg.gain_i};
            end
            MUL_T_GFF: begin
                mul_a = {{(MUL_A_W-SAMPLE_W){tgt_reg[SAMPLE_W-1]}}, tgt_reg};
                mul_b = {cfg.gain_ff[GAIN_W-1], cfg.gain_ff};
            end
            MUL_FL_GD: begin
                mul_a = {{(MUL_A_W-SPLIT_W){1'b0}}, f_reg[SPLIT_W-1:0]};
                mul_b = {cfg.gain_d[GAIN_W-1], cfg.gain_d};
            end
            MUL_FH_GD: begin
                mul_a = {{(MUL_A_W-FILT_W+SPLIT_W){f_reg[FILT_W-1]}},
                         f_reg[FILT_W-1:SPLIT_W]};
                mul_b = {cfg.gain_d[GAIN_W-1], cfg.gain_d};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // integral sum, clamp and freeze windows
    always_comb begin
        isum_next = {{(ISUM_W-INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg}
                  + prod_reg[ISUM_W-1:0];
        cap_pos   = {{(ISUM_W-CAP_W){1'b0}}, cfg.integral_cap};
        cap_neg   = -cap_pos;
        priority if (isum_reg > cap_pos) begin
            clamped = cap_pos;
        end else if (isum_reg < cap_neg) begin
            clamped = cap_neg;
        end else begin
            clamped = isum_reg;
        end
        e_mag  = e_reg[ERR_W-1] ? ERR_W'(-e_reg) : ERR_W'(e_reg);
        frozen = (e_mag < cfg.window_inner) || (e_mag > cfg.window_outer);
        integ_new_next = frozen ? integ_reg : clamped[INTEG_W-1:0];
    end

    // filter step: alpha*(d-f)/65536 toward zero, added to the filter state
    always_comb begin
        f_round = acc_reg[ACC_W-1] && (acc_reg[DERIV_FRAC-1:0] != '0);
        f_sum   = {f_reg[FILT_W-1], f_reg} + acc_reg[DIFF_W+DERIV_FRAC-1:DERIV_FRAC]
                + {{(DIFF_W-1){1'b0}}, f_round};
        f_next  = f_sum[FILT_W-1:0];
    end

    // final scaling toward zero and the huge check on the non-derivative part
    always_comb begin
        q_round   = acc_reg[ACC_W-1] && (acc_reg[SHIFT-1:0] != '0);
        q_next    = $signed(acc_reg[ACC_W-1:SHIFT]) + $signed({{(QW-1){1'b0}}, q_round});
        huge_next = (acc_reg > HUGE_POS) || (acc_reg < HUGE_NEG);
    end

    // accumulator
    always_comb begin
        acc_next = acc_reg;
        unique case (cmd.acc_op)
            ACC_HOLD:      acc_next = acc_reg;
            ACC_ISUM:      acc_next = acc_reg;
            ACC_LOAD_HI:   acc_next = prod_ext <<< SPLIT_W;
            ACC_ADD:       acc_next = acc_reg + prod_ext;
            ACC_FILT_LOAD: acc_next = prod_ext;
            ACC_SHIFT_ADD: acc_next = (acc_reg <<< DERIV_FRAC) + prod_ext;
            ACC_ADD_HI:    acc_next = acc_reg + (prod_ext <<< SPLIT_W);
            ACC_QUOT:      acc_next = acc_reg;
            default:       acc_next = acc_reg;
        endcase
    end

    // saturation of the command
    always_comb begin
        priority if (huge_reg) begin
            drive_next = huge_neg_reg ? -D_LIM : D_LIM;
            sat_next   = 1'b1;
        end else if (q_reg > Q_LIM) begin
            drive_next = D_LIM;
            sat_next   = 1'b1;
        end else if (q_reg < -Q_LIM) begin
            drive_next = -D_LIM;
            sat_next   = 1'b1;
        end else begin
            drive_next = q_reg[DRIVE_W-1:0];
            sat_next   = 1'b0;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            tgt_reg <= s_target;
            dt_reg  <= s_elapsed_ticks;
            e_reg   <= {s_target[SAMPLE_W-1], s_target} - {s_measured[SAMPLE_W-1], s_measured};
        end
        if (cmd.diff_load) begin
            diff_reg <= diff_next;
        end
        if (cmd.acc_op == ACC_ISUM) begin
            isum_reg <= isum_next;
        end
        if (cmd.clamp_load) begin
            integ_new_reg <= integ_new_next;
        end
        if (cmd.acc_op == ACC_SHIFT_ADD) begin
            huge_reg     <= huge_next;
            huge_neg_reg <= acc_reg[ACC_W-1];
        end
        if (cmd.acc_op == ACC_QUOT) begin
            q_reg <= q_next;
        end
        if (cmd.out_load) begin
            m_drive_reg     <= drive_next;
            m_saturated_reg <= sat_next;
        end
        prod_reg <= mul_a * mul_b;
        acc_reg  <= acc_next;
    end

    // state kept across samples and the output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg    <= '0;
            integ_reg   <= '0;
            f_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.acc_op == ACC_FILT_LOAD) begin
                f_reg <= f_next;
            end
            if (cmd.out_load) begin
                prev_reg    <= e_reg;
                integ_reg   <= integ_new_reg;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_drive         = m_drive_reg;
    assign m_saturated     = m_saturated_reg;

    `PEDC_ASSERT(a_drive_in_range, m_valid_reg |-> (m_drive_reg <= D_LIM && m_drive_reg >= -D_LIM), "drive outside the output limit")
    `PEDC_ASSERT(a_commit_error, cmd.out_load |=> (prev_reg == $past(e_reg)), "previous error not committed with the result")
    `PEDC_ASSERT_RST(a_reset_clears_valid, !aresetn |=> !m_valid_reg, "output valid survived reset")

endmodule

// File: hdl/pid_ema_derivative_controller_top.sv
// PID controller with a smoothed derivative and target feed-forward. Each input
// word (target, measured, elapsed_ticks) yields one output word (drive, saturated).
// The result lands in the output register after a sequence of steps from the
// accepting edge: eight products through the one shared 26x25 multiplier into a
// 64-bit accumulator, one last accumulate, one scaling step, and a step to
// saturate and load the result. The sequencer handles one sample at a time, so
// the next sample is taken in the cycle after the result is loaded; no new
// sample is taken before the last one is through. That result may still be
// waiting on m_ready; a stalled output register holds the sequencer in its last
// step. Configuration writes take effect on the next clock edge and are meant
// for idle periods only.
module pid_ema_derivative_controller_top
    import pedc_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    parameter int OUT_LIMIT      = OUT_LIMIT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]                cfg_index,
    input  logic [CFG_DATA_W-1:0]               cfg_wr_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_W-1:0]          s_target,
    input  logic signed [SAMPLE_W-1:0]          s_measured,
    input  logic        [SAMPLE_W-1:0]          s_elapsed_ticks,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [$clog2(OUT_LIMIT+1):0] m_drive,
    output logic                                m_saturated
);

    pedc_cfg_t    cfg;
    pedc_cmd_t    cmd;
    pedc_status_t status;

    pedc_cfg_regs u_cfg_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    pedc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pedc_datapath #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .OUT_LIMIT      (OUT_LIMIT)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .s_target        (s_target),
        .s_measured      (s_measured),
        .s_elapsed_ticks (s_elapsed_ticks),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive         (m_drive),
        .m_saturated     (m_saturated)
    );

endmodule

// File: tb/sv/pid_ema_derivative_controller_top_tb.sv
module pid_ema_derivative_controller_top_tb;
    import pedc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int      DRV_W       = $clog2(OUT_LIMIT_DEF + 1) + 1;
    localparam longint  UNITY       = 64'sd65536;
    localparam longint  SCALE       = 64'sd1 <<< (GAIN_FRAC_BITS_DEF + DERIV_FRAC);
    localparam longint  HUGE_LIM    = 64'sd1 <<< 46;
    localparam longint  LIM         = longint'(OUT_LIMIT_DEF);
    localparam int      NUM_PHASES  = 8;
    localparam int      PHASE_ITEMS = 125;
    localparam int      END_GAP     = 40;
    localparam int      CYCLE_LIMIT = 500000;
    localparam int      MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [DRV_W-1:0] drive;
        logic                    sat;
    } drive_word_t;

    typedef enum logic [1:0] {
        ROW_REG,
        ROW_KNOWN,
        ROW_CALC
    } row_kind_t;

    typedef enum logic [1:0] {
        PH_MODERATE,
        PH_FULL,
        PH_EXTREME
    } phase_mode_t;

    typedef struct packed {
        row_kind_t                kind;
        cfg_index_t               reg_idx;
        logic [CFG_DATA_W-1:0]    reg_val;
        logic signed [SAMPLE_W-1:0] tgt;
        logic signed [SAMPLE_W-1:0] meas;
        logic [SAMPLE_W-1:0]      ticks;
        drive_word_t              want;
    } stim_row_t;

    // clock, reset and block inputs
    logic                         aclk            = 1'b0;
    logic                         aresetn         = 1'b0;
    logic                         cfg_wr_en       = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index       = '0;
    logic [CFG_DATA_W-1:0]        cfg_wr_data     = '0;
    logic                         s_valid         = 1'b0;
    logic                         s_ready;
    logic signed [SAMPLE_W-1:0]   s_target        = '0;
    logic signed [SAMPLE_W-1:0]   s_measured      = '0;
    logic [SAMPLE_W-1:0]          s_elapsed_ticks = '0;
    logic                         m_valid;
    logic                         m_ready         = 1'b0;
    logic signed [DRV_W-1:0]      m_drive;
    logic                         m_saturated;

    // register copies and loop state of the controller model
    longint gp_m      = 0;
    longint gi_m      = 0;
    longint gd_m      = 0;
    longint gff_m     = 0;
    longint cap_m     = 100000;
    longint win_in_m  = 0;
    longint win_out_m = 131071;
    longint alpha_m   = 65536;
    longint err_m     = 0;
    longint integ_m   = 0;
    longint deriv_m   = 0;

    drive_word_t pending_drive_q[$];

    bit idle_on    = 1'b0;
    int stall_left = 0;
    int sent_cnt    = 0;
    int checked_cnt = 0;
    int sat_cnt     = 0;
    int reg_wr_cnt  = 0;
    int fail_cnt    = 0;
    int cycle_cnt   = 0;

    pid_ema_derivative_controller_top DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_target        (s_target),
        .s_measured      (s_measured),
        .s_elapsed_ticks (s_elapsed_ticks),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive         (m_drive),
        .m_saturated     (m_saturated)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic longint abs64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // one control step: integral with clamp and freeze, smoothed derivative, sum
    function automatic drive_word_t predict_drive(input logic signed [SAMPLE_W-1:0] tgt,
                                                  input logic signed [SAMPLE_W-1:0] meas,
                                                  input logic [SAMPLE_W-1:0] ticks);
        longint      e;
        longint      acc;
        longint      d;
        longint      alpha;
        longint      a_sum;
        longint      total;
        longint      q;
        drive_word_t r;
        e   = longint'(tgt) - longint'(meas);
        acc = integ_m + e * longint'(ticks);
        if (abs64(acc) > cap_m) acc = (acc < 0) ? -cap_m : cap_m;
        // freeze keeps the old value, even above a lowered cap
        if (abs64(e) < win_in_m || abs64(e) > win_out_m) acc = integ_m;

        // derivative in 16 fraction bits, falling edges quartered
        d = e - err_m;
        d = (d < 0) ? d * (UNITY / 4) : d * UNITY;
        alpha   = (alpha_m > UNITY) ? UNITY : alpha_m;
        deriv_m = deriv_m + (alpha * (d - deriv_m)) / UNITY;

        a_sum = e * gp_m + acc * gi_m + longint'(tgt) * gff_m;
        if (abs64(a_sum) > HUGE_LIM) begin
            q = (a_sum < 0) ? -LIM - 1 : LIM + 1;
        end else begin
            total = a_sum * UNITY + deriv_m * gd_m;
            q     = total / SCALE;
        end

        r.sat = 1'b0;
        if (q > LIM) begin
            q     = LIM;
            r.sat = 1'b1;
        end else if (q < -LIM) begin
            q     = -LIM;
            r.sat = 1'b1;
        end
        r.drive = q[DRV_W-1:0];
        err_m   = e;
        integ_m = acc;
        return r;
    endfunction

    function automatic stim_row_t reg_row(input cfg_index_t idx,
                                          input logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r         = '0;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic stim_row_t calc_row(input int t, input int m, input int k);
        stim_row_t r;
        r       = '0;
        r.kind  = ROW_CALC;
        r.tgt   = t[SAMPLE_W-1:0];
        r.meas  = m[SAMPLE_W-1:0];
        r.ticks = k[SAMPLE_W-1:0];
        return r;
    endfunction

    function automatic stim_row_t known_row(input int t, input int m, input int k,
                                            input int drv, input bit sat);
        stim_row_t r;
        r            = calc_row(t, m, k);
        r.kind       = ROW_KNOWN;
        r.want.drive = drv[DRV_W-1:0];
        r.want.sat   = sat;
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_signed(input int span);
        int v;
        v = int'($urandom_range(0, 2 * span)) - span;
        return v[CFG_DATA_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] clamp16(input int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic note_fail(input string msg);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS) $display("[%0t] %s", $time, msg);
    endtask

    // drop valid and hold until every outstanding word has come back
    task automatic wait_settled();
        s_valid <= 1'b0;
        while (pending_drive_q.size() != 0) @(posedge aclk);
    endtask

    // register write, only with the pipeline empty
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        wait_settled();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        reg_wr_cnt++;
        case (idx)
            REG_GAIN_P:       gp_m      = longint'($signed(val));
            REG_GAIN_I:       gi_m      = longint'($signed(val));
            REG_GAIN_D:       gd_m      = longint'($signed(val));
            REG_GAIN_FF:      gff_m     = longint'($signed(val));
            REG_INTEGRAL_CAP: cap_m     = longint'(val);
            REG_WINDOW_INNER: win_in_m  = longint'(val[WIN_W-1:0]);
            REG_WINDOW_OUTER: win_out_m = longint'(val[WIN_W-1:0]);
            REG_EMA_ALPHA:    alpha_m   = longint'(val[ALPHA_W-1:0]);
            default: ;
        endcase
    endtask

    // present one sample word, optional idle burst first
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] t,
                               input logic signed [SAMPLE_W-1:0] m,
                               input logic [SAMPLE_W-1:0] k,
                               input bit use_want, input drive_word_t want);
        drive_word_t calc;
        int          gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
        cfg_wr_en <= 1'b0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_target        <= t;
        s_measured      <= m;
        s_elapsed_ticks <= k;
        do @(posedge aclk); while (!s_ready);
        calc = predict_drive(t, m, k);
        pending_drive_q.push_back(use_want ? want : calc);
        sent_cnt++;
    endtask

    // all eight registers for one random phase
    task automatic program_phase(input phase_mode_t mode);
        logic [CFG_DATA_W-1:0] v[8];
        case (mode)
            PH_MODERATE: begin
                v[0] = rand_signed(8192);
                v[1] = rand_signed(64);
                v[2] = rand_signed(4096);
                v[3] = rand_signed(512);
                v[4] = CFG_DATA_W'($urandom_range(0, 60000));
                v[5] = CFG_DATA_W'($urandom_range(0, 300));
                v[6] = CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(200, 5000)
                                                        : $urandom_range(200, 131071));
                v[7] = CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(0, 131071)
                                                        : 65536);
            end
            PH_FULL: begin
                foreach (v[i]) v[i] = CFG_DATA_W'($urandom);
            end
            default: begin
                v[0] = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                v[1] = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                v[2] = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                v[3] = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                v[4] = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
                v[5] = $urandom_range(0, 1) ? 24'h01FFFF : 24'h000000;
                v[6] = $urandom_range(0, 1) ? 24'h01FFFF : 24'h000000;
                case ($urandom_range(0, 2))
                    0:       v[7] = 24'h000000;
                    1:       v[7] = 24'h010000;
                    default: v[7] = 24'h01FFFF;
                endcase
            end
        endcase
        write_reg(REG_GAIN_P,       v[0]);
        write_reg(REG_GAIN_I,       v[1]);
        write_reg(REG_GAIN_D,       v[2]);
        write_reg(REG_GAIN_FF,      v[3]);
        write_reg(REG_INTEGRAL_CAP, v[4]);
        write_reg(REG_WINDOW_INNER, v[5]);
        write_reg(REG_WINDOW_OUTER, v[6]);
        write_reg(REG_EMA_ALPHA,    v[7]);
    endtask

    // receiver stalls in random bursts, started only while idle_on is set
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result word checker
    always @(posedge aclk) begin : result_check
        drive_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (m_saturated) sat_cnt++;
            if (pending_drive_q.size() == 0) begin
                note_fail($sformatf("unexpected word drive=%0d sat=%0b", m_drive, m_saturated));
            end else begin
                want = pending_drive_q.pop_front();
                checked_cnt++;
                if (m_drive !== want.drive || m_saturated !== want.sat) begin
                    note_fail($sformatf(
                        "word %0d mismatch: drive exp %0d got %0d, sat exp %0b got %0b",
                        checked_cnt, want.drive, m_drive, want.sat, m_saturated));
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_cnt, pending_drive_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        stim_row_t              dir_rows[$];
        phase_mode_t            mode;
        logic signed [SAMPLE_W-1:0] trk;
        logic signed [SAMPLE_W-1:0] t;
        logic signed [SAMPLE_W-1:0] m;
        logic [SAMPLE_W-1:0]    k;

        // reset gains give zero drive at the field extremes
        dir_rows.push_back(known_row( 32767, -32768, 65535,    0, 1'b0));
        dir_rows.push_back(known_row(-32768,  32767, 65535,    0, 1'b0));
        dir_rows.push_back(known_row(     0,      0,     0,    0, 1'b0));
        // feed-forward alone, full scale then unity gain around the limit
        dir_rows.push_back(reg_row(REG_GAIN_FF, 24'h7FFFFF));
        dir_rows.push_back(known_row( 32767,      0,     1,  127, 1'b1));
        dir_rows.push_back(known_row(-32768,      0,     1, -127, 1'b1));
        dir_rows.push_back(reg_row(REG_GAIN_FF, 24'h001000));
        dir_rows.push_back(known_row(   127,      0,     0,  127, 1'b0));
        dir_rows.push_back(known_row(   128,      0,     0,  127, 1'b1));
        dir_rows.push_back(known_row(  -127,      0,     0, -127, 1'b0));
        dir_rows.push_back(known_row(  -128,      0,     0, -127, 1'b1));
        // integral driven to a full cap, then huge sums of either sign
        dir_rows.push_back(reg_row(REG_GAIN_FF, 24'h000000));
        dir_rows.push_back(reg_row(REG_INTEGRAL_CAP, 24'hFFFFFF));
        dir_rows.push_back(calc_row( 32767, -32768, 65535));
        dir_rows.push_back(reg_row(REG_GAIN_I, 24'h800000));
        dir_rows.push_back(known_row(     1,      0,     1, -127, 1'b1));
        dir_rows.push_back(reg_row(REG_GAIN_I, 24'h7FFFFF));
        dir_rows.push_back(known_row(     1,      0,     1,  127, 1'b1));
        // freeze windows with the cap lowered under the held integral
        dir_rows.push_back(reg_row(REG_GAIN_I, 24'h000001));
        dir_rows.push_back(reg_row(REG_WINDOW_INNER, 24'd1000));
        dir_rows.push_back(reg_row(REG_WINDOW_OUTER, 24'd2000));
        dir_rows.push_back(reg_row(REG_INTEGRAL_CAP, 24'd0));
        dir_rows.push_back(calc_row(   500,      0,    10));
        dir_rows.push_back(calc_row(  3000,      0,    10));
        dir_rows.push_back(calc_row(  1500,      0,    10));
        dir_rows.push_back(reg_row(REG_GAIN_I, 24'h001000));
        dir_rows.push_back(reg_row(REG_INTEGRAL_CAP, 24'd100));
        dir_rows.push_back(calc_row( -1000,      0,     5));
        dir_rows.push_back(calc_row(  2000,      0,     5));
        dir_rows.push_back(calc_row(  2001,      0,     5));
        // derivative: zero alpha, alpha above one, partial smoothing
        dir_rows.push_back(reg_row(REG_GAIN_I, 24'h000000));
        dir_rows.push_back(reg_row(REG_WINDOW_INNER, 24'd0));
        dir_rows.push_back(reg_row(REG_WINDOW_OUTER, 24'h01FFFF));
        dir_rows.push_back(reg_row(REG_GAIN_D, 24'h001000));
        dir_rows.push_back(reg_row(REG_EMA_ALPHA, 24'd0));
        dir_rows.push_back(calc_row(  1000,      0,     1));
        dir_rows.push_back(calc_row(     0,      0,     1));
        dir_rows.push_back(reg_row(REG_EMA_ALPHA, 24'h01FFFF));
        dir_rows.push_back(calc_row(-32768,  32767,     1));
        dir_rows.push_back(calc_row( 32767, -32768,     1));
        dir_rows.push_back(reg_row(REG_EMA_ALPHA, 24'd16384));
        dir_rows.push_back(calc_row(   100,      0,     1));
        dir_rows.push_back(reg_row(REG_GAIN_P, 24'h800000));
        dir_rows.push_back(calc_row( 32767, -32768,     1));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        idle_on = 1'b1;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_REG) begin
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end else begin
                send_sample(dir_rows[i].tgt, dir_rows[i].meas, dir_rows[i].ticks,
                            dir_rows[i].kind == ROW_KNOWN, dir_rows[i].want);
            end
        end

        // random phases, mostly a tracking loop with some raw noise words
        trk = '0;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph < 3) mode = phase_mode_t'(ph);
            else mode = ($urandom_range(0, 3) < 2) ? PH_MODERATE
                                                    : phase_mode_t'($urandom_range(1, 2));
            idle_on = !(ph == 3 || ph == NUM_PHASES - 1);
            program_phase(mode);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 1 && n == 60) wait_settled();
                if ($urandom_range(0, 9) < 7) begin
                    if ($urandom_range(0, 19) == 0) trk = SAMPLE_W'($urandom);
                    else trk = clamp16(int'(trk) + int'($urandom_range(0, 128)) - 64);
                    t = trk;
                    m = clamp16(int'(trk) + int'($urandom_range(0, 800)) - 400);
                    k = SAMPLE_W'($urandom_range(1, 40));
                end else begin
                    t = SAMPLE_W'($urandom);
                    m = SAMPLE_W'($urandom);
                    k = SAMPLE_W'($urandom);
                end
                send_sample(t, m, k, 1'b0, '0);
            end
        end

        // drain and let the pipeline go quiet
        cfg_wr_en <= 1'b0;
        wait_settled();
        repeat (END_GAP) @(posedge aclk);

        $display("%0d samples over %0d register phases, %0d register writes",
                 sent_cnt, NUM_PHASES + 1, reg_wr_cnt);
        $display("%0d words checked, %0d clipped, %0d failures", checked_cnt, sat_cnt, fail_cnt);
        if (fail_cnt == 0 && pending_drive_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
